FILE: sv/rotating_disc_release_predictor_unit_assert.svh
// Assertion macros used by the predictor unit.
`ifndef ROTATING_DISC_RELEASE_PREDICTOR_UNIT_ASSERT_SVH
`define ROTATING_DISC_RELEASE_PREDICTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rdrp_pkg.sv
package rdrp_pkg;

  // Width of the signed working word used by the serial arithmetic units.
  localparam int CALC_W = 56;
  // Width of the multiplier operand that is scanned one bit per cycle.
  localparam int MUL_B_W = 26;

  localparam int FALL_TIME_MS_DEF = 400;
  localparam int SECTORS_PER_TURN_DEF = 12;

  // Fixed-point scale constants.
  localparam logic [MUL_B_W-1:0] SPEED_NUM = 26'd32768000;
  localparam logic [MUL_B_W-1:0] ACCEL_SCALE = 26'd1000;
  localparam logic [MUL_B_W-1:0] AVG_DIV = 26'd2000;
  localparam logic [MUL_B_W-1:0] REV_DIV = 26'd65536000;
  localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

  localparam int SAT_IN_W = CALC_W + 2;

  typedef enum logic [3:0] {
    OP_START      = 4'd0,
    OP_END        = 4'd1,
    OP_SPEED      = 4'd2,
    OP_SAVE_OLD   = 4'd3,
    OP_ACCEL      = 4'd4,
    OP_SECTOR     = 4'd5,
    OP_CLEAR      = 4'd6,
    OP_SECTOR_TIM = 4'd7,
    OP_PREDICT    = 4'd8
  } op_t;

  // States of the serial arithmetic units.
  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_RUN  = 3'b010,
    U_FIX  = 3'b100
  } unit_state_t;

  // Status returned by an arithmetic unit to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(64'sh7FFFFFFF);
    lo = -hi - SAT_IN_W'(1);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: sv/rdrp_mul.sv
// Bit-serial shift-add multiplier: signed a times unsigned b, one bit of b per cycle.
module rdrp_mul
  import rdrp_pkg::*;
#(
  parameter int CalcW = CALC_W,
  parameter int MulBW = MUL_B_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CalcW-1:0] a,
  input  logic [MulBW-1:0]        b,
  output logic signed [CalcW-1:0] prod,
  output unit_stat_t              stat
);

  unit_state_t             state;
  logic signed [CalcW-1:0] areg;
  logic [MulBW-1:0]        breg;
  logic                    done_pulse;

  assign stat = '{busy: (state != U_IDLE), done: done_pulse};

  // Add the shifted multiplicand for each set bit, lowest bit first.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= U_IDLE;
      done_pulse <= 1'b0;
    end else begin
      done_pulse <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            prod  <= '0;
            areg  <= a;
            breg  <= b;
            state <= U_RUN;
          end
        end
        U_RUN: begin
          if (breg[0]) begin
            prod <= prod + areg;
          end
          areg <= areg <<< 1;
          breg <= breg >> 1;
          if (breg[MulBW-1:1] == '0) begin
            done_pulse <= 1'b1;
            state      <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/rdrp_div.sv
// Bit-serial restoring divider with floor rounding for signed operands.
module rdrp_div
  import rdrp_pkg::*;
#(
  parameter int CalcW = CALC_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CalcW-1:0] num,
  input  logic signed [CalcW-1:0] den,
  output logic signed [CalcW-1:0] quot,
  output unit_stat_t              stat
);

  localparam int CntW = $clog2(CalcW);

  unit_state_t       state;
  logic [CntW-1:0]   cnt;
  logic [CalcW-1:0]  qn;
  logic [CalcW-1:0]  rem;
  logic [CalcW-1:0]  dmag;
  logic              neg;
  logic [CalcW-1:0]  rem_shift;
  logic              done_pulse;

  assign stat = '{busy: (state != U_IDLE), done: done_pulse};
  assign rem_shift = {rem[CalcW-2:0], qn[CalcW-1]};

  // One quotient bit per cycle on magnitudes, then a sign and floor fix.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= U_IDLE;
      done_pulse <= 1'b0;
    end else begin
      done_pulse <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            qn    <= num[CalcW-1] ? -num : num;
            dmag  <= den[CalcW-1] ? -den : den;
            neg   <= num[CalcW-1] ^ den[CalcW-1];
            rem   <= '0;
            cnt   <= '0;
            state <= U_RUN;
          end
        end
        U_RUN: begin
          if (rem_shift >= dmag) begin
            rem <= rem_shift - dmag;
            qn  <= {qn[CalcW-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            qn  <= {qn[CalcW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(CalcW - 1)) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          if (neg) begin
            quot <= -$signed(qn) - ((rem != '0) ? CalcW'(1) : CalcW'(0));
          end else begin
            quot <= $signed(qn);
          end
          done_pulse <= 1'b1;
          state      <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/rotating_disc_release_predictor_unit.sv
// Disc release predictor. An event is taken when start is high and busy is low;
// its one result beat appears on wait_ms, speed and status while done is high
// for a single cycle, and must be taken then since the receiver cannot stall.
// Timing events (stamps, sector count) go straight to the result beat; compute
// speed, compute acceleration and predict (which ends early when the average
// speed comes out zero) run on the 56-step bit-serial divider and the
// up-to-26-step shift-add multiplier, which those three events share, one
// unit at a time.
// latency_ms sits at APB address 0.
module rotating_disc_release_predictor_unit
  import rdrp_pkg::*;
#(
  parameter int FALL_TIME_MS = FALL_TIME_MS_DEF,
  parameter int SECTORS_PER_TURN = SECTORS_PER_TURN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation,
  input  logic [31:0]        now_ms,
  output logic               done,
  output logic signed [31:0] wait_ms,
  output logic [23:0]        speed,
  output logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "rotating_disc_release_predictor_unit_assert.svh"

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_SPD_DIV = 14'b00000000000010,
    ST_ACC_MUL = 14'b00000000000100,
    ST_ACC_DIV = 14'b00000000001000,
    ST_PR_MUL1 = 14'b00000000010000,
    ST_PR_DIV1 = 14'b00000000100000,
    ST_PR_MUL2 = 14'b00000001000000,
    ST_PR_DIV2 = 14'b00000010000000,
    ST_PR_MUL3 = 14'b00000100000000,
    ST_PR_MUL4 = 14'b00001000000000,
    ST_PR_MUL5 = 14'b00010000000000,
    ST_PR_DIV3 = 14'b00100000000000,
    ST_PR_FIN  = 14'b01000000000000,
    ST_OUT     = 14'b10000000000000
  } step_t;

  // Event state.
  logic [31:0]        start_stamp;
  logic [31:0]        end_stamp;
  logic [23:0]        disc_speed;
  logic [23:0]        previous_speed;
  logic [31:0]        previous_speed_stamp;
  logic signed [31:0] disc_accel;
  logic [7:0]         sectors_seen;
  logic [31:0]        sector_stamp;
  logic [15:0]        latency_ms;

  // Sequencer.
  step_t                    step;
  logic                     launched;
  logic [31:0]              now_reg;
  logic signed [CALC_W-1:0] avg;
  logic signed [CALC_W-1:0] tmp;
  logic signed [31:0]       wait_val;
  logic                     stat_val;

  // Arithmetic unit connections.
  logic                     mul_start;
  logic signed [CALC_W-1:0] mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic signed [CALC_W-1:0] mul_q;
  unit_stat_t               mul_stat;
  logic                     div_start;
  logic signed [CALC_W-1:0] div_n;
  logic signed [CALC_W-1:0] div_d;
  logic signed [CALC_W-1:0] div_q;
  unit_stat_t               div_stat;

  logic                     accept;
  logic                     cfg_write;
  logic [31:0]              half_dt;
  logic [31:0]              acc_dt;
  logic [31:0]              sec_dt;
  logic signed [24:0]       spd_diff;
  logic signed [CALC_W-1:0] avg_next;
  logic signed [SAT_IN_W-1:0] q_ext;
  logic signed [SAT_IN_W-1:0] fin_sum;
  logic [23:0]              spd_sat;

  assign busy      = (step != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == 3'd0) ? {16'd0, latency_ms} : 32'd0;

  assign half_dt  = end_stamp - start_stamp;
  assign acc_dt   = now_reg - previous_speed_stamp;
  assign sec_dt   = now_reg - sector_stamp;
  assign spd_diff = $signed({1'b0, disc_speed}) - $signed({1'b0, previous_speed});
  assign avg_next = $signed({{(CALC_W-24){1'b0}}, disc_speed}) + div_q;
  assign q_ext    = {{2{div_q[CALC_W-1]}}, div_q};
  assign fin_sum  = {{2{tmp[CALC_W-1]}}, tmp} - SAT_IN_W'(FALL_TIME_MS)
                    - SAT_IN_W'(latency_ms);
  assign spd_sat  = (div_q > $signed({{(CALC_W-24){1'b0}}, SPEED_MAX})) ?
                    SPEED_MAX : div_q[23:0];

  // Operands for the step in progress; a unit is started once per step.
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = tmp;
    mul_b     = MUL_B_W'(SECTORS_PER_TURN);
    div_n     = mul_q;
    div_d     = mul_q;
    case (step)
      ST_SPD_DIV: begin
        div_start = !launched;
        div_n     = $signed({{(CALC_W-MUL_B_W){1'b0}}, SPEED_NUM});
        div_d     = $signed({{(CALC_W-32){1'b0}}, half_dt});
      end
      ST_ACC_MUL: begin
        mul_start = !launched;
        mul_a     = {{(CALC_W-25){spd_diff[24]}}, spd_diff};
        mul_b     = ACCEL_SCALE;
      end
      ST_ACC_DIV: begin
        div_start = !launched;
        div_d     = $signed({{(CALC_W-32){1'b0}}, acc_dt});
      end
      ST_PR_MUL1: begin
        mul_start = !launched;
        mul_a     = {{(CALC_W-32){disc_accel[31]}}, disc_accel};
        mul_b     = MUL_B_W'(FALL_TIME_MS);
      end
      ST_PR_DIV1: begin
        div_start = !launched;
        div_d     = $signed({{(CALC_W-MUL_B_W){1'b0}}, AVG_DIV});
      end
      ST_PR_MUL2: begin
        mul_start = !launched;
        mul_a     = avg;
        mul_b     = MUL_B_W'(FALL_TIME_MS);
      end
      ST_PR_DIV2: begin
        div_start = !launched;
        div_d     = $signed({{(CALC_W-MUL_B_W){1'b0}}, REV_DIV});
      end
      ST_PR_MUL3: begin
        mul_start = !launched;
      end
      ST_PR_MUL4: begin
        mul_start = !launched;
        mul_b     = REV_DIV;
      end
      ST_PR_MUL5: begin
        mul_start = !launched;
        mul_a     = avg;
      end
      ST_PR_DIV3: begin
        div_start = !launched;
        div_n     = tmp;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  rdrp_mul #(
    .CalcW (CALC_W),
    .MulBW (MUL_B_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_q),
    .stat  (mul_stat)
  );

  rdrp_div #(
    .CalcW (CALC_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .quot  (div_q),
    .stat  (div_stat)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      latency_ms <= '0;
    end else if (cfg_write && paddr == 3'd0) begin
      latency_ms <= pwdata[15:0];
    end
  end

  // Event sequencer and state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      step                 <= ST_IDLE;
      launched             <= 1'b0;
      done                 <= 1'b0;
      start_stamp          <= '0;
      end_stamp            <= '0;
      disc_speed           <= '0;
      previous_speed       <= '0;
      previous_speed_stamp <= '0;
      disc_accel           <= '0;
      sectors_seen         <= '0;
      sector_stamp         <= '0;
    end else begin
      done <= 1'b0;
      if (mul_start || div_start) begin
        launched <= 1'b1;
      end else if (mul_stat.done || div_stat.done) begin
        launched <= 1'b0;
      end
      case (step)
        ST_IDLE: begin
          if (accept) begin
            now_reg  <= now_ms;
            wait_val <= '0;
            stat_val <= 1'b0;
            step     <= ST_OUT;
            case (operation)
              OP_START:      start_stamp <= now_ms;
              OP_END:        end_stamp <= now_ms;
              OP_SPEED: begin
                if (half_dt == '0) begin
                  stat_val <= 1'b1;
                end else begin
                  step <= ST_SPD_DIV;
                end
              end
              OP_SAVE_OLD: begin
                previous_speed       <= disc_speed;
                previous_speed_stamp <= now_ms;
              end
              OP_ACCEL: begin
                if (now_ms == previous_speed_stamp) begin
                  stat_val <= 1'b1;
                end else begin
                  step <= ST_ACC_MUL;
                end
              end
              OP_SECTOR: begin
                if (sectors_seen != 8'hFF) begin
                  sectors_seen <= sectors_seen + 8'd1;
                end
              end
              OP_CLEAR:      sectors_seen <= '0;
              OP_SECTOR_TIM: sector_stamp <= now_ms;
              OP_PREDICT:    step <= ST_PR_MUL1;
              default:       step <= ST_OUT;
            endcase
          end
        end
        ST_SPD_DIV: begin
          if (div_stat.done) begin
            disc_speed <= spd_sat;
            step       <= ST_OUT;
          end
        end
        ST_ACC_MUL: if (mul_stat.done) step <= ST_ACC_DIV;
        ST_ACC_DIV: begin
          if (div_stat.done) begin
            disc_accel <= sat32(q_ext);
            step       <= ST_OUT;
          end
        end
        ST_PR_MUL1: if (mul_stat.done) step <= ST_PR_DIV1;
        ST_PR_DIV1: begin
          if (div_stat.done) begin
            avg <= avg_next;
            if (avg_next == '0) begin
              stat_val <= 1'b1;
              step     <= ST_OUT;
            end else begin
              step <= ST_PR_MUL2;
            end
          end
        end
        ST_PR_MUL2: if (mul_stat.done) step <= ST_PR_DIV2;
        ST_PR_DIV2: begin
          if (div_stat.done) begin
            tmp  <= div_q + CALC_W'(1);
            step <= ST_PR_MUL3;
          end
        end
        ST_PR_MUL3: begin
          if (mul_stat.done) begin
            tmp  <= mul_q + CALC_W'(SECTORS_PER_TURN)
                    - $signed({{(CALC_W-8){1'b0}}, sectors_seen});
            step <= ST_PR_MUL4;
          end
        end
        ST_PR_MUL4: begin
          if (mul_stat.done) begin
            tmp  <= mul_q;
            step <= ST_PR_MUL5;
          end
        end
        ST_PR_MUL5: if (mul_stat.done) step <= ST_PR_DIV3;
        ST_PR_DIV3: begin
          if (div_stat.done) begin
            tmp  <= div_q - $signed({{(CALC_W-32){1'b0}}, sec_dt});
            step <= ST_PR_FIN;
          end
        end
        ST_PR_FIN: begin
          wait_val <= sat32(fin_sum);
          step     <= ST_OUT;
        end
        ST_OUT: begin
          done    <= 1'b1;
          wait_ms <= wait_val;
          speed   <= disc_speed;
          status  <= stat_val;
          step    <= ST_IDLE;
        end
        default: step <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the shared units.
  `RDRP_ASSERT_NEXT(a_accept_progress, accept, busy || done,
    "accepted event neither in progress nor answered")
  `RDRP_ASSERT_NOW(a_done_idle, done, !busy, "result beat while sequencer busy")
  `RDRP_ASSERT_NOW(a_status_wait, done && status, wait_ms == 32'sd0,
    "failed event gave a nonzero wait")
  `RDRP_ASSERT_NOW(a_one_unit, mul_stat.busy, !div_stat.busy,
    "multiplier and divider busy together")

endmodule
